// ===== design/fmsc_pkg.sv =====
// Types, widths and shared arithmetic helpers for the factorisation machine scorer.
// No dependencies; imported by every module of the block.
package fmsc_pkg;

  localparam int NumFactorPorts = 8;
  localparam int ValW           = 16;
  localparam int DW             = 20;  // rounded product, Q.12
  localparam int SumW           = 48;  // linear and factor sums
  localparam int SqW            = 37;  // square of a rounded product
  localparam int SqSumW         = 56;  // running square sum
  localparam int PsqW           = 63;  // square of the clamped factor sum
  localparam int TermW          = 51;  // pairwise term of one lane
  localparam int ScoreW         = 56;  // exact score before saturation
  localparam int FiuW           = 4;
  localparam int ProbW          = 16;
  localparam int RawW           = 32;
  localparam int CfgIdxW        = 1;

  localparam logic [CfgIdxW-1:0] RegBias    = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFactors = 1'b1;

  // Step enables from the sequencer to every lane cell.
  typedef struct packed {
    logic d_en;       // form the rounded product
    logic sq_en;      // add it into the factor sum, square it
    logic sqacc_en;   // add the square into the square sum
    logic square_en;  // square the clamped factor sum
    logic term_en;    // form the pairwise term
    logic chain_en;   // advance the score along the row
    logic clear;      // drop the accumulators
  } cell_ctrl_t;

  // Q4.12 times Q4.12, rounded back to Q.12.
  function automatic logic signed [DW-1:0] qmul_round(logic signed [ValW-1:0] a,
                                                      logic signed [ValW-1:0] b);
    logic signed [2*ValW-1:0] p;
    p = a * b;
    p = p + 32'sd2048;
    return p[2*ValW-1:12];
  endfunction

  // Saturating add of a rounded product into a 48 bit sum.
  function automatic logic signed [SumW-1:0] sat_add_sum(logic signed [SumW-1:0] acc,
                                                         logic signed [DW-1:0] d);
    logic signed [SumW:0] s;
    s = {acc[SumW-1], acc} + (SumW+1)'(d);
    if (s[SumW] != s[SumW-1]) begin
      return s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end
    return s[SumW-1:0];
  endfunction

  // Saturate the score to 32 bit signed.
  function automatic logic [RawW-1:0] sat_raw(logic signed [ScoreW-1:0] s);
    if ((&s[ScoreW-1:RawW-1]) || !(|s[ScoreW-1:RawW-1])) begin
      return s[RawW-1:0];
    end
    return s[ScoreW-1] ? {1'b1, {(RawW-1){1'b0}}} : {1'b0, {(RawW-1){1'b1}}};
  endfunction

  // Piecewise-linear sigmoid, Q.12 in, unsigned Q0.16 out.
  function automatic logic [ProbW-1:0] sigmoid_q16(logic signed [ScoreW-1:0] s);
    logic [ScoreW-1:0] mag;
    logic [14:0]       a;
    logic [16:0]       y;
    mag = s[ScoreW-1] ? ScoreW'(-s) : s;
    a   = (mag > ScoreW'(20480)) ? 15'd20480 : mag[14:0];
    priority if (a < 15'd4096) begin
      y = {a, 2'b00} + 17'd32768;
    end else if (a < 15'd9728) begin
      y = {1'b0, a, 1'b0} + 17'd40960;
    end else begin
      y = 17'(a >> 1) + 17'd55296;
    end
    if (s[ScoreW-1]) begin
      y = 17'd65536 - y;
    end
    if (y > 17'd65535) begin
      return 16'hFFFF;
    end
    return y[15:0];
  endfunction

endpackage

// ===== design/fmsc_cell.sv =====
// One factor lane of the scorer: running sum and square sum, pairwise term,
// and one link of the score row. Depends on fmsc_pkg.
module fmsc_cell
  import fmsc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [ValW-1:0]   factor_i,
  input  logic signed [ValW-1:0]   value_i,
  input  logic                     in_use_i,
  input  logic signed [ScoreW-1:0] score_i,
  output logic signed [ScoreW-1:0] score_o
);

  logic signed [DW-1:0]     d_q;
  logic signed [SumW-1:0]   fsum_q, fsum_d;
  logic        [SqW-1:0]    sq_q;
  logic        [SqSumW-1:0] sqsum_q, sqsum_d;
  logic        [PsqW-1:0]   psq_q;
  logic signed [TermW-1:0]  term_q;
  logic signed [ScoreW-1:0] score_q, score_d;

  logic signed [2*DW-1:0]   sq_full;
  logic        [SqSumW:0]   sqsum_ext;
  logic signed [31:0]       fs32;
  logic signed [63:0]       psq_full;
  logic signed [63:0]       diff;

  assign sq_full   = d_q * d_q;
  assign sqsum_ext = {1'b0, sqsum_q} + (SqSumW+1)'(sq_q);
  assign fs32      = ((&fsum_q[SumW-1:31]) || !(|fsum_q[SumW-1:31])) ? fsum_q[31:0] :
                     (fsum_q[SumW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  assign psq_full  = fs32 * fs32;
  assign diff      = $signed({1'b0, psq_q}) - $signed({8'b0, sqsum_q}) + 64'sd4096;

  always_comb begin
    fsum_d  = fsum_q;
    sqsum_d = sqsum_q;
    if (ctrl_i.clear) begin
      fsum_d  = '0;
      sqsum_d = '0;
    end else begin
      if (ctrl_i.sq_en) begin
        fsum_d = sat_add_sum(fsum_q, d_q);
      end
      if (ctrl_i.sqacc_en) begin
        // saturate at the top of the unsigned range
        sqsum_d = sqsum_ext[SqSumW] ? {SqSumW{1'b1}} : sqsum_ext[SqSumW-1:0];
      end
    end
  end

  assign score_d = score_i + ScoreW'(term_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsum_q  <= '0;
      sqsum_q <= '0;
    end else begin
      fsum_q  <= fsum_d;
      sqsum_q <= sqsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.d_en) begin
      d_q <= qmul_round(factor_i, value_i);
    end
    if (ctrl_i.sq_en) begin
      sq_q <= sq_full[SqW-1:0];
    end
    if (ctrl_i.square_en) begin
      psq_q <= psq_full[PsqW-1:0];
    end
    if (ctrl_i.term_en) begin
      term_q <= in_use_i ? diff[63:13] : '0;
    end
    if (ctrl_i.chain_en) begin
      score_q <= score_d;
    end
  end

  assign score_o = score_q;

endmodule

// ===== design/factorization_machine_score.sv =====
// Top level of the order-2 factorisation machine scorer: input capture, linear
// lane, sequencer and the row of factor lane cells. Depends on fmsc_pkg, fmsc_cell.
//
// Usage: drive one active feature per item on the payload ports and pulse
// start_i; the item is taken at a clock edge with start_i high and busy_o low.
// Each factor has its own lane cell holding that factor's running sum and
// square sum. An item not marked last_feature_i holds busy_o only through its
// capture and rounded multiply, so the next item may be taken while it
// accumulates. The item marked last_feature_i holds busy_o while the
// accumulation finishes, every lane squares its clamped sum and forms its
// pairwise term, and the score then ripples through the row of MAX_FACTORS
// cells one cell per cycle before the sigmoid stage.
// The result is shown on probability_o and raw_score_o for exactly one cycle
// with done_o high; the receiver cannot hold it off, so capture it then. The
// accumulators are cleared on that same cycle and a new sample may start while
// done_o is high. Write bias_weight (index 0) and factors_in_use (index 1)
// only while busy_o is low and no sample is part way through.
module factorization_machine_score
  import fmsc_pkg::*;
#(
  parameter int MAX_FACTORS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // item port
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [ValW-1:0]   feature_value_i,
  input  logic signed [ValW-1:0]   linear_weight_i,
  input  logic signed [ValW-1:0]   factor_0_i,
  input  logic signed [ValW-1:0]   factor_1_i,
  input  logic signed [ValW-1:0]   factor_2_i,
  input  logic signed [ValW-1:0]   factor_3_i,
  input  logic signed [ValW-1:0]   factor_4_i,
  input  logic signed [ValW-1:0]   factor_5_i,
  input  logic signed [ValW-1:0]   factor_6_i,
  input  logic signed [ValW-1:0]   factor_7_i,
  input  logic                     last_feature_i,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [ValW-1:0]          cfg_wdata_i,
  // result
  output logic                     done_o,
  output logic [ProbW-1:0]         probability_o,
  output logic signed [RawW-1:0]   raw_score_o
);

  localparam int CntW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSquare = 3'd1;
  localparam logic [2:0] StTerm   = 3'd2;
  localparam logic [2:0] StChain  = 3'd3;
  localparam logic [2:0] StOut    = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  // configuration registers
  logic signed [ValW-1:0] bias_q;
  logic [FiuW-1:0]        fiu_q;

  // captured item
  logic                   in_vld_q;
  logic                   in_last_q;
  logic signed [ValW-1:0] val_q;
  logic signed [ValW-1:0] wgt_q;
  logic signed [ValW-1:0] fac_q [NumFactorPorts];
  logic signed [ValW-1:0] fac_in [NumFactorPorts];

  // accumulate pipeline
  logic                   d_vld_q, d_last_q;
  logic                   sq_vld_q, sq_last_q;
  logic signed [DW-1:0]   lin_d_q;
  logic signed [SumW-1:0] linear_sum_q, linear_sum_d;

  // result
  logic                   done_q;
  logic [ProbW-1:0]       prob_q;
  logic [RawW-1:0]        raw_q;

  logic                     accept;
  cell_ctrl_t               ctrl;
  logic signed [ScoreW-1:0] base;
  logic signed [ScoreW-1:0] score [MAX_FACTORS];
  logic signed [ScoreW-1:0] final_score;

  assign accept = start_i && !busy_o;

  assign fac_in[0] = factor_0_i;
  assign fac_in[1] = factor_1_i;
  assign fac_in[2] = factor_2_i;
  assign fac_in[3] = factor_3_i;
  assign fac_in[4] = factor_4_i;
  assign fac_in[5] = factor_5_i;
  assign fac_in[6] = factor_6_i;
  assign fac_in[7] = factor_7_i;

  // Hold off new items while a captured item is being multiplied, and for the
  // whole of a sample's closing sequence.
  assign busy_o = in_vld_q || (d_vld_q && d_last_q) || (sq_vld_q && sq_last_q) ||
                  (state_q != StIdle);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
      fiu_q  <= FiuW'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegBias:    bias_q <= cfg_wdata_i;
        RegFactors: fiu_q  <= cfg_wdata_i[FiuW-1:0];
        default:    ;
      endcase
    end
  end

  // item capture and the valid flags of the accumulate pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      d_vld_q   <= 1'b0;
      sq_vld_q  <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      d_vld_q   <= in_vld_q;
      sq_vld_q  <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q     <= feature_value_i;
      wgt_q     <= linear_weight_i;
      in_last_q <= last_feature_i;
      for (int i = 0; i < NumFactorPorts; i++) begin
        fac_q[i] <= fac_in[i];
      end
    end
    if (in_vld_q) begin
      lin_d_q  <= qmul_round(wgt_q, val_q);
      d_last_q <= in_last_q;
    end
    if (d_vld_q) begin
      sq_last_q <= d_last_q;
    end
  end

  // linear lane
  always_comb begin
    linear_sum_d = linear_sum_q;
    if (state_q == StOut) begin
      linear_sum_d = '0;
    end else if (d_vld_q) begin
      linear_sum_d = sat_add_sum(linear_sum_q, lin_d_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_sum_q <= '0;
    end else begin
      linear_sum_q <= linear_sum_d;
    end
  end

  // closing sequence: square, term, ripple along the row, output
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (sq_vld_q && sq_last_q) begin
          state_d = StSquare;
        end
      end
      StSquare: state_d = StTerm;
      StTerm: begin
        state_d = StChain;
        cnt_d   = '0;
      end
      StChain: begin
        if (cnt_q == CntW'(MAX_FACTORS - 1)) begin
          state_d = StOut;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    ctrl.d_en      = in_vld_q;
    ctrl.sq_en     = d_vld_q;
    ctrl.sqacc_en  = sq_vld_q;
    ctrl.square_en = (state_q == StSquare);
    ctrl.term_en   = (state_q == StTerm);
    ctrl.chain_en  = (state_q == StChain);
    ctrl.clear     = (state_q == StOut);
  end

  // The head of the row starts from bias plus linear sum; each cell adds its
  // own term and passes the total on.
  assign base = ScoreW'(bias_q) + ScoreW'(linear_sum_q);

  for (genvar g = 0; g < MAX_FACTORS; g++) begin : g_lane
    logic signed [ScoreW-1:0] score_in;
    logic                     in_use;
    assign score_in = (g == 0) ? base : score[(g == 0) ? 0 : g - 1];
    assign in_use   = (fiu_q > FiuW'(g));
    fmsc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .factor_i (fac_q[g]),
      .value_i  (val_q),
      .in_use_i (in_use),
      .score_i  (score_in),
      .score_o  (score[g])
    );
  end

  assign final_score = score[MAX_FACTORS-1];

  // result register: one strobe per sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == StOut);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StOut) begin
      prob_q <= sigmoid_q16(final_score);
      raw_q  <= sat_raw(final_score);
    end
  end

  assign done_o        = done_q;
  assign probability_o = prob_q;
  assign raw_score_o   = raw_q;

endmodule

// ===== design/fmsc_checker.sv =====
// Port-level checks for the factorisation machine scorer, bound to its top level.
// Depends on fmsc_pkg for field widths.
module fmsc_checker
  import fmsc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   done_o,
  input logic [ProbW-1:0]       probability_o,
  input logic signed [RawW-1:0] raw_score_o
);

  // A taken item always occupies the block for the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o low right after an item was taken");

  // A result strobe ends the closing sequence of a sample.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && $past(busy_o)))
    else $error("result strobe not at the end of a busy period");

  // One strobe per sample.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // Probability lies on the side of one half that the score's sign picks.
  a_prob_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (raw_score_o[RawW-1] ? (probability_o <= 16'd32768)
                                    : (probability_o >= 16'd32768)))
    else $error("probability on the wrong side of one half");

endmodule

bind factorization_machine_score fmsc_checker u_fmsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .probability_o (probability_o),
  .raw_score_o   (raw_score_o)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for factorization_machine_score: streams samples of active features,
// predicts every click score and its sigmoid, and checks each result on done_o.
// Depends on fmsc_pkg and the factorization_machine_score RTL only.
module tb;
  import fmsc_pkg::*;

  localparam int MaxFactors   = 8;
  localparam int RandItems    = 1050;
  localparam int NumPhases    = 10;
  localparam int SettleCycles = 40;      // outlasts the busy period of a sample's last item
  localparam int CycleLimit   = 400000;
  localparam int CalmFrom     = 300;     // items in this window go out with no gaps
  localparam int CalmTo       = 560;

  localparam longint S48Hi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48Lo = -S48Hi - 1;
  localparam longint U56Hi = 64'sh00FF_FFFF_FFFF_FFFF;
  localparam longint S32Hi = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32Lo = -S32Hi - 1;

  typedef enum int {FlvWide, FlvNarrow, FlvEdge, FlvAlternate} flavour_e;

  // One active feature as it goes onto the item port.
  typedef struct packed {
    logic [ValW-1:0]                     value;
    logic [ValW-1:0]                     weight;
    logic [NumFactorPorts-1:0][ValW-1:0] fac;
    logic                                last;
  } feature_t;

  // One expected click score.
  typedef struct packed {
    logic [ProbW-1:0] prob;
    logic [RawW-1:0]  raw;
  } score_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // item port, owned by the driver
  logic     start_q  = 1'b0;
  feature_t drv_item = '0;
  logic     took_q   = 1'b0;
  logic     busy;

  // configuration port, owned by the stimulus process
  logic               cfg_we_q   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_q  = '0;
  logic [ValW-1:0]    cfg_data_q = '0;

  logic                   done;
  logic [ProbW-1:0]       probability;
  logic signed [RawW-1:0] raw_score;

  feature_t pending_q[$];   // features waiting for the driver
  score_t   score_q[$];     // click scores still owed by the block

  // Shadow of the block's registers and accumulators.
  longint bias_reg  = 0;
  int     lanes_reg = MaxFactors;
  longint lin_acc   = 0;
  longint fac_acc[NumFactorPorts];
  longint fac_sq_acc[NumFactorPorts];

  int     errors     = 0;
  int     scored     = 0;
  int     items_sent = 0;
  int     settings   = 1;
  int     cycle_cnt  = 0;
  score_t want;

  always #1 clk = ~clk;

  factorization_machine_score #(
    .MAX_FACTORS(MaxFactors)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start_q),
    .busy_o         (busy),
    .feature_value_i(drv_item.value),
    .linear_weight_i(drv_item.weight),
    .factor_0_i     (drv_item.fac[0]),
    .factor_1_i     (drv_item.fac[1]),
    .factor_2_i     (drv_item.fac[2]),
    .factor_3_i     (drv_item.fac[3]),
    .factor_4_i     (drv_item.fac[4]),
    .factor_5_i     (drv_item.fac[5]),
    .factor_6_i     (drv_item.fac[6]),
    .factor_7_i     (drv_item.fac[7]),
    .last_feature_i (drv_item.last),
    .cfg_we_i       (cfg_we_q),
    .cfg_index_i    (cfg_idx_q),
    .cfg_wdata_i    (cfg_data_q),
    .done_o         (done),
    .probability_o  (probability),
    .raw_score_o    (raw_score)
  );

  // ---------------------------------------------------------------------------
  // Score predictor
  // ---------------------------------------------------------------------------

  function automatic longint sx16(logic [ValW-1:0] u);
    return longint'($signed(u));
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Q4.12 times Q4.12, rounded half up back to Q.12.
  function automatic longint qround(longint a, longint b);
    return (a * b + 2048) >>> 12;
  endfunction

  // Piecewise-linear sigmoid: slope 1/4 near zero, then 1/8, then 1/32, flat beyond 5.0.
  function automatic logic [ProbW-1:0] squash(longint sc);
    longint a;
    longint y;
    a = (sc < 0) ? -sc : sc;
    if (a > 20480) a = 20480;
    if (a < 4096) begin
      y = 4 * a + 32768;
    end else if (a < 9728) begin
      y = 2 * a + 40960;
    end else begin
      y = a / 2 + 55296;
    end
    if (sc < 0) y = 65536 - y;
    if (y > 65535) y = 65535;
    return ProbW'(y);
  endfunction

  // Fold one accepted feature into the shadow sums; on the last feature of a
  // sample, owe a score and drop the sums.
  task automatic fold_feature(input feature_t it);
    longint v;
    longint d;
    longint s;
    longint score;
    int     used;
    int     f;
    v = sx16(it.value);
    lin_acc = clamp(lin_acc + qround(sx16(it.weight), v), S48Lo, S48Hi);
    // every lane accumulates, whether or not it is in use
    for (f = 0; f < NumFactorPorts; f++) begin
      d = qround(sx16(it.fac[f]), v);
      fac_acc[f]    = clamp(fac_acc[f] + d, S48Lo, S48Hi);
      fac_sq_acc[f] = clamp(fac_sq_acc[f] + d * d, 0, U56Hi);
    end
    if (it.last) begin
      used  = (lanes_reg > MaxFactors) ? MaxFactors : lanes_reg;
      score = bias_reg + lin_acc;
      for (f = 0; f < used; f++) begin
        s = clamp(fac_acc[f], S32Lo, S32Hi);
        score += (s * s - fac_sq_acc[f] + 4096) >>> 13;
      end
      score_q.push_back('{prob: squash(score), raw: RawW'(clamp(score, S32Lo, S32Hi))});
      lin_acc = 0;
      for (f = 0; f < NumFactorPorts; f++) begin
        fac_acc[f]    = 0;
        fac_sq_acc[f] = 0;
      end
    end
  endtask

  initial begin
    for (int f = 0; f < NumFactorPorts; f++) begin
      fac_acc[f]    = 0;
      fac_sq_acc[f] = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present the next feature at the falling edge once the previous one
  // has been taken; idle about one cycle in five outside the calm window.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!start_q || took_q) begin
      if (pending_q.size() != 0 &&
          ((items_sent >= CalmFrom && items_sent < CalmTo) || $urandom_range(0, 99) >= 20)) begin
        drv_item   <= pending_q.pop_front();
        start_q    <= 1'b1;
        items_sent <= items_sent + 1;
      end else begin
        start_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample at the rising edge. Check a result first, then track
  // register writes and fold in the feature taken at this edge, so that a
  // score owed at this very edge is never matched against an older result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      took_q <= 1'b0;
    end else begin
      took_q <= start_q && !busy;
      if (done) begin
        if (score_q.size() == 0) begin
          $error("result with no score owed: probability %0d raw_score %0d",
                 probability, raw_score);
          errors++;
        end else begin
          want = score_q.pop_front();
          scored++;
          if (probability !== want.prob) begin
            $error("probability: expected %0d, got %0d", want.prob, probability);
            errors++;
          end
          if (raw_score !== want.raw) begin
            $error("raw_score: expected %0d, got %0d", $signed(want.raw), raw_score);
            errors++;
          end
        end
      end
      if (cfg_we_q) begin
        case (cfg_idx_q)
          RegBias:    bias_reg  = sx16(cfg_data_q);
          RegFactors: lanes_reg = int'(cfg_data_q[FiuW-1:0]);
          default:    ;
        endcase
      end
      if (start_q && !busy) begin
        fold_feature(drv_item);
      end
    end
  end

  // Watchdog: the slowest legal run is far inside this.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $error("timeout: %0d scores still owed, %0d features unsent",
             score_q.size(), pending_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Write one register at the falling edge, for one cycle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValW-1:0] data);
    @(negedge clk);
    cfg_we_q   <= 1'b1;
    cfg_idx_q  <= idx;
    cfg_data_q <= data;
    @(negedge clk);
    cfg_we_q   <= 1'b0;
  endtask

  // Hold until every feature is taken and every owed score has arrived, then
  // let the pipeline run dry.
  task automatic drain();
    while (pending_q.size() != 0 || start_q || score_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic queue_feature(input logic [ValW-1:0] value, input logic [ValW-1:0] weight,
                               input logic [NumFactorPorts-1:0][ValW-1:0] fac,
                               input logic last);
    pending_q.push_back('{value: value, weight: weight, fac: fac, last: last});
  endtask

  function automatic logic [ValW-1:0] pick_field(flavour_e flv, int span);
    case (flv)
      FlvNarrow: return ValW'(int'($urandom_range(0, 2 * span)) - span);
      FlvEdge: begin
        case ($urandom_range(0, 5))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          4:       return 16'h0001;
          default: return ValW'($urandom);
        endcase
      end
      default: return ValW'($urandom);
    endcase
  endfunction

  // Queue one well-formed sample of len features, the last one marked.
  task automatic queue_sample(input flavour_e flv, input int len);
    feature_t it;
    int       span;
    int       n;
    int       f;
    span = 1 << $urandom_range(4, 14);
    for (n = 0; n < len; n++) begin
      it.value  = pick_field(flv, span);
      it.weight = pick_field(flv, span);
      for (f = 0; f < NumFactorPorts; f++) it.fac[f] = pick_field(flv, span);
      // full-scale products of alternating sign: factor sums cancel while the
      // square sums grow, driving the pairwise term hard negative
      if (flv == FlvAlternate) begin
        it.value = 16'h8000;
        for (f = 0; f < NumFactorPorts; f++) it.fac[f] = (n % 2) ? 16'h7FFF : 16'h8000;
      end
      it.last = (n == len - 1);
      pending_q.push_back(it);
    end
  endtask

  initial begin : stimulus
    int               ph;
    int               phase_items;
    int               roll;
    int               len;
    flavour_e         flv;
    logic [ValW-1:0]  bias;
    logic [FiuW-1:0]  lanes;
    logic [ValW-1:0]  data;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset values of the registers (bias 0, all lanes).
    // All-zero feature: score is exactly zero, probability one half.
    queue_feature(16'h0000, 16'h0000, '0, 1'b1);
    // Largest positive and most negative operands everywhere.
    queue_feature(16'h7FFF, 16'h7FFF, {NumFactorPorts{16'h7FFF}}, 1'b1);
    queue_feature(16'h8000, 16'h8000, {NumFactorPorts{16'h8000}}, 1'b1);
    // Mixed signs across the lanes.
    queue_feature(16'h8000, 16'h7FFF, {(NumFactorPorts / 2){16'h7FFF, 16'h8000}}, 1'b1);
    // Seven identical full-scale features: the raw score saturates high.
    repeat (6) queue_feature(16'h8000, 16'h8000, {NumFactorPorts{16'h8000}}, 1'b0);
    queue_feature(16'h8000, 16'h8000, {NumFactorPorts{16'h8000}}, 1'b1);
    // Two features of opposite sign per lane: the pairwise term turns negative.
    queue_feature(16'h7FFF, 16'h0000, {NumFactorPorts{16'h7FFF}}, 1'b0);
    queue_feature(16'h7FFF, 16'h0000, {NumFactorPorts{16'h8000}}, 1'b1);
    // Zero feature value: weights and factors count for nothing.
    queue_feature(16'h0000, 16'($urandom), {$urandom, $urandom, $urandom, $urandom}, 1'b1);
    // Smallest positive value against random weights.
    queue_feature(16'h0001, 16'($urandom), {$urandom, $urandom, $urandom, $urandom}, 1'b1);
    drain();

    // Random part in phases, each under its own register setting.
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       begin bias = 16'h7FFF;      lanes = FiuW'(MaxFactors); end
        1:       begin bias = 16'h8000;      lanes = 4'd1;              end
        2:       begin bias = 16'h0000;      lanes = 4'd0;              end  // no pairwise term
        3:       begin bias = 16'($urandom); lanes = 4'd15;             end  // clipped to the lanes built
        4:       begin bias = 16'h8000;      lanes = FiuW'(MaxFactors); end
        default: begin bias = 16'($urandom); lanes = FiuW'($urandom_range(0, 15)); end
      endcase
      write_reg(RegBias, bias);
      // fill the unused upper bits of the write data with noise
      data = 16'($urandom);
      data[FiuW-1:0] = lanes;
      write_reg(RegFactors, data);
      settings++;

      phase_items = 0;
      // a long cancelling sample under full lanes and the lowest bias: the raw
      // score saturates low
      if (ph == 4) begin
        queue_sample(FlvAlternate, 70);
        phase_items += 70;
      end
      while (phase_items < RandItems / NumPhases) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          flv = FlvWide;
          len = $urandom_range(1, 5);
        end else if (roll < 80) begin
          flv = FlvNarrow;
          len = $urandom_range(1, 8);
        end else if (roll < 95) begin
          flv = FlvEdge;
          len = $urandom_range(1, 10);
        end else begin
          flv = FlvAlternate;
          len = $urandom_range(2, 20);
        end
        queue_sample(flv, len);
        phase_items += len;
      end
      drain();
    end

    if (score_q.size() != 0) begin
      $error("%0d scores never arrived", score_q.size());
      errors++;
    end
    $display("Scored %0d samples from %0d features under %0d register settings,",
             scored, items_sent, settings);
    $display("covering bias and lane-count extremes, saturated scores and all sigmoid bands.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fmsc_pkg.sv
design/fmsc_cell.sv
design/factorization_machine_score.sv
design/fmsc_checker.sv
dv/tb.sv
